// ===== rtl/sbsh_pkg.sv =====
// Shared types and constants of the SHA-256 byte stream hasher.
`timescale 1ns / 1ps

package sbsh_pkg;

   localparam int unsigned ROUNDS = 64;
   localparam int unsigned CHAIN_WORDS = 8;

   localparam logic [7:0] PAD_MARK = 8'h80;
   localparam logic [7:0] PAD_ZERO = 8'h00;
   localparam logic [5:0] LEN_FILL = 6'd56;
   localparam logic [5:0] LAST_FILL = 6'd63;
   localparam logic [5:0] LAST_ROUND = 6'd63;
   localparam logic [1:0] LAST_SLICE = 2'd3;

   localparam logic [31:0] ROUND_K [ROUNDS] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] IV_WORDS [CHAIN_WORDS] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   typedef struct packed {
      logic       push;
      logic       use_input;
      logic       pad_mark;
      logic       count;
      logic       load_len;
      logic       start_round;
      logic       do_round;
      logic       add_chain;
      logic       load_digest;
      logic [5:0] round_idx;
      logic [1:0] out_idx;
   } sbsh_cmd_type;

   typedef struct packed {
      logic [5:0] fill;
   } sbsh_status_type;

endpackage

// ===== rtl/sbsh_datapath.sv =====
// Datapath: block buffer and message schedule, round registers, chain and digest.
`timescale 1ns / 1ps

module sbsh_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  sbsh_pkg::sbsh_cmd_type   cmd,
   input  logic [7:0]               req_data_byte,
   output sbsh_pkg::sbsh_status_type status,
   output logic [63:0]              rsp_digest_word
);

   logic [511:0] blk_ff, blk_in;
   logic [31:0]  wrk_ff [sbsh_pkg::CHAIN_WORDS];
   logic [31:0]  wrk_in [sbsh_pkg::CHAIN_WORDS];
   logic [31:0]  h_ff [sbsh_pkg::CHAIN_WORDS];
   logic [31:0]  h_in [sbsh_pkg::CHAIN_WORDS];
   logic [255:0] dig_ff, dig_in;
   logic [5:0]   fill_ff, fill_in;
   logic [63:0]  bytes_ff, bytes_in;

   logic [7:0]   push_val;
   logic [31:0]  w_new, t1, t2, ch, maj;

   function automatic logic [31:0] big_s0(input logic [31:0] x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic logic [31:0] big_s1(input logic [31:0] x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic logic [31:0] small_s0(input logic [31:0] x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
   endfunction

   function automatic logic [31:0] small_s1(input logic [31:0] x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
   endfunction

   // The block buffer doubles as the 16-word schedule window; word 0 sits in the top bits.
   assign w_new = blk_ff[511:480] + small_s0(blk_ff[479:448]) + blk_ff[223:192]
                  + small_s1(blk_ff[63:32]);
   assign ch    = (wrk_ff[4] & wrk_ff[5]) ^ (~wrk_ff[4] & wrk_ff[6]);
   assign maj   = (wrk_ff[0] & wrk_ff[1]) ^ (wrk_ff[0] & wrk_ff[2]) ^ (wrk_ff[1] & wrk_ff[2]);
   assign t1    = wrk_ff[7] + big_s1(wrk_ff[4]) + ch + sbsh_pkg::ROUND_K[cmd.round_idx]
                  + blk_ff[511:480];
   assign t2    = big_s0(wrk_ff[0]) + maj;

   assign push_val = cmd.use_input ? req_data_byte
                   : (cmd.pad_mark ? sbsh_pkg::PAD_MARK : sbsh_pkg::PAD_ZERO);

   always_comb begin
      blk_in   = blk_ff;
      wrk_in   = wrk_ff;
      h_in     = h_ff;
      dig_in   = dig_ff;
      fill_in  = fill_ff;
      bytes_in = bytes_ff;
      if (cmd.push) begin
         blk_in  = {blk_ff[503:0], push_val};
         fill_in = fill_ff + 6'd1;
      end
      if (cmd.count) begin
         bytes_in = bytes_ff + 64'd1;
      end
      if (cmd.load_len) begin
         // The bit length fills the last eight bytes of the final block at once.
         blk_in  = {blk_ff[447:0], bytes_ff[60:0], 3'b000};
         fill_in = '0;
      end
      if (cmd.start_round) begin
         wrk_in = h_ff;
      end
      if (cmd.do_round) begin
         blk_in = {blk_ff[479:0], w_new};
         wrk_in = '{t1 + t2, wrk_ff[0], wrk_ff[1], wrk_ff[2],
                    wrk_ff[3] + t1, wrk_ff[4], wrk_ff[5], wrk_ff[6]};
      end
      if (cmd.add_chain) begin
         for (int i = 0; i < sbsh_pkg::CHAIN_WORDS; i++) begin
            h_in[i] = h_ff[i] + wrk_ff[i];
         end
      end
      if (cmd.load_digest) begin
         dig_in   = {h_ff[0], h_ff[1], h_ff[2], h_ff[3], h_ff[4], h_ff[5], h_ff[6], h_ff[7]};
         h_in     = sbsh_pkg::IV_WORDS;
         fill_in  = '0;
         bytes_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_ff     <= sbsh_pkg::IV_WORDS;
         fill_ff  <= '0;
         bytes_ff <= '0;
      end else begin
         h_ff     <= h_in;
         fill_ff  <= fill_in;
         bytes_ff <= bytes_in;
      end
   end

   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
      wrk_ff <= wrk_in;
      dig_ff <= dig_in;
   end

   always_comb begin
      case (cmd.out_idx)
         2'd0:    rsp_digest_word = dig_ff[255:192];
         2'd1:    rsp_digest_word = dig_ff[191:128];
         2'd2:    rsp_digest_word = dig_ff[127:64];
         default: rsp_digest_word = dig_ff[63:0];
      endcase
   end

   assign status.fill = fill_ff;

endmodule

// ===== rtl/sbsh_control.sv =====
// Controller: byte intake, padding sequence, round counting and digest slice output.
`timescale 1ns / 1ps

module sbsh_control (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_end_of_message,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [1:0]                rsp_word_index,
   output logic                      rsp_last_word,
   input  sbsh_pkg::sbsh_status_type status,
   output sbsh_pkg::sbsh_cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_PAD,
      S_ROUND,
      S_ADD,
      S_DONE
   } state_type;

   state_type  state_ff, state_in;
   logic [5:0] rnd_ff, rnd_in;
   logic       in_pad_ff, in_pad_in;
   logic       mark_ff, mark_in;
   logic       final_ff, final_in;
   logic       out_busy_ff, out_busy_in;
   logic [1:0] idx_ff, idx_in;

   always_comb begin
      state_in    = state_ff;
      rnd_in      = rnd_ff;
      in_pad_in   = in_pad_ff;
      mark_in     = mark_ff;
      final_in    = final_ff;
      out_busy_in = out_busy_ff;
      idx_in      = idx_ff;
      cmd           = '0;
      cmd.round_idx = rnd_ff;
      cmd.out_idx   = idx_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.push      = 1'b1;
               cmd.use_input = 1'b1;
               cmd.count     = 1'b1;
               if (status.fill == sbsh_pkg::LAST_FILL) begin
                  cmd.start_round = 1'b1;
                  rnd_in    = '0;
                  in_pad_in = req_end_of_message;
                  mark_in   = 1'b0;
                  final_in  = 1'b0;
                  state_in  = S_ROUND;
               end else if (req_end_of_message) begin
                  in_pad_in = 1'b1;
                  mark_in   = 1'b0;
                  final_in  = 1'b0;
                  state_in  = S_PAD;
               end
            end
         end
         S_PAD: begin
            if (mark_ff && status.fill == sbsh_pkg::LEN_FILL) begin
               cmd.load_len    = 1'b1;
               cmd.start_round = 1'b1;
               rnd_in   = '0;
               final_in = 1'b1;
               state_in = S_ROUND;
            end else begin
               // The first padding byte is the end marker, the rest are zeros.
               cmd.push     = 1'b1;
               cmd.pad_mark = ~mark_ff;
               mark_in      = 1'b1;
               if (status.fill == sbsh_pkg::LAST_FILL) begin
                  cmd.start_round = 1'b1;
                  rnd_in   = '0;
                  state_in = S_ROUND;
               end
            end
         end
         S_ROUND: begin
            cmd.do_round = 1'b1;
            rnd_in       = rnd_ff + 6'd1;
            if (rnd_ff == sbsh_pkg::LAST_ROUND) begin
               state_in = S_ADD;
            end
         end
         S_ADD: begin
            cmd.add_chain = 1'b1;
            if (final_ff) begin
               state_in = S_DONE;
            end else if (in_pad_ff) begin
               state_in = S_PAD;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_DONE: begin
            // The digest waits here until the previous one has been fully taken.
            if (!out_busy_ff) begin
               cmd.load_digest = 1'b1;
               out_busy_in = 1'b1;
               idx_in      = '0;
               in_pad_in   = 1'b0;
               mark_in     = 1'b0;
               final_in    = 1'b0;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (out_busy_ff && !rsp_stall) begin
         idx_in = idx_ff + 2'd1;
         if (idx_ff == sbsh_pkg::LAST_SLICE) begin
            out_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         rnd_ff      <= '0;
         in_pad_ff   <= 1'b0;
         mark_ff     <= 1'b0;
         final_ff    <= 1'b0;
         out_busy_ff <= 1'b0;
         idx_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         rnd_ff      <= rnd_in;
         in_pad_ff   <= in_pad_in;
         mark_ff     <= mark_in;
         final_ff    <= final_in;
         out_busy_ff <= out_busy_in;
         idx_ff      <= idx_in;
      end
   end

   assign req_stall      = (state_ff != S_IDLE);
   assign rsp_valid      = out_busy_ff;
   assign rsp_word_index = idx_ff;
   assign rsp_last_word  = (idx_ff == sbsh_pkg::LAST_SLICE);

endmodule

// ===== rtl/sha256_byte_stream_hasher.sv =====
// SHA-256 over a byte stream: top level joining controller and datapath.
//
// Usage: the request channel carries one message byte per transfer, with
// req_end_of_message set on the last byte of each message (messages hold at
// least one byte). A byte is taken at a clock edge where req_valid is high and
// req_stall is low. Bytes are taken one per cycle until the 64-byte block is
// full; the block then runs its 64 rounds and a chain update while intake
// stalls, so the speed on a long message is set by the single shared round
// unit. After the last byte the block pads itself one byte per cycle, with the
// bit length loaded in a single step, and runs one or two more compressions
// before the first digest slice appears.
// The digest then leaves on the response channel as four 64-bit slices, word
// index 0 (most significant) first, rsp_last_word marking index 3. The digest
// sits in its own output register, so bytes of the next message are taken
// while the slices drain; a following digest waits until all four slices of
// the previous one have been transferred. While rsp_stall is high the
// current slice holds. Synchronous reset restores the initial hash values
// and empties the block and the byte count; no clearing pass is needed.
`timescale 1ns / 1ps

module sha256_byte_stream_hasher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_digest_word,
   output logic [1:0]  rsp_word_index,
   output logic        rsp_last_word
);

   sbsh_pkg::sbsh_cmd_type    cmd;
   sbsh_pkg::sbsh_status_type status;

   sbsh_control u_control (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_end_of_message (req_end_of_message),
      .req_stall          (req_stall),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_word_index     (rsp_word_index),
      .rsp_last_word      (rsp_last_word),
      .status             (status),
      .cmd                (cmd)
   );

   sbsh_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_data_byte   (req_data_byte),
      .status          (status),
      .rsp_digest_word (rsp_digest_word)
   );

endmodule

// ===== rtl/sbsh_checker.sv =====
// Port-level checks of the hasher's digest output, bound to the top level.
`timescale 1ns / 1ps

module sbsh_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_end_of_message,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [63:0] rsp_digest_word,
   input logic [1:0]  rsp_word_index,
   input logic        rsp_last_word
);

   // A stalled slice keeps its data and position.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_digest_word)
                                 && $stable(rsp_word_index))
      else $error("stalled digest slice changed");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_word == (rsp_word_index == 2'd3)))
      else $error("last word flag does not match slice index");

   // Slices of one digest follow each other without a gap.
   a_next_slice: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_word
         |=> rsp_valid && (rsp_word_index == $past(rsp_word_index) + 2'd1))
      else $error("digest slice sequence broken");

   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_last_word |=> !rsp_valid)
      else $error("new digest shown right after the last slice");

   // The last byte of a message always starts padding or a compression, so intake pauses.
   a_stall_after_end: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_end_of_message |=> req_stall)
      else $error("byte intake continued after the end of a message");

endmodule

bind sha256_byte_stream_hasher sbsh_checker u_sbsh_checker (.*);

// ===== bench/sha256_byte_stream_hasher_test.sv =====
// Self-checking testbench for the SHA-256 byte stream hasher, with its own digest predictor.
`timescale 1ns / 1ps

module sha256_byte_stream_hasher_test;

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned DRAIN_CYCLES = 300;
   localparam int unsigned RANDOM_BYTES = 100;
   localparam int unsigned RANDOM_MESSAGES = 6;
   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam logic [1:0] FINAL_SLICE = 2'd3;

   localparam logic [255:0] ABC_DIGEST =
      256'hba7816bf_8f01cfea_414140de_5dae2223_b00361a3_96177a9c_b410ff61_f20015ad;

   localparam logic [31:0] ROUND_CONST [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] START_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   typedef struct packed {
      logic [7:0]   data;
      logic         last_byte;
      logic         known;
      logic [255:0] digest;
   } byte_row_type;

   typedef struct packed {
      logic [63:0] word;
      logic [1:0]  index;
      logic        last;
   } digest_slice_type;

   // Rows with a known digest carry it; the others are checked by the predictor.
   localparam int unsigned DIRECTED_ROWS = 13;
   localparam byte_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{8'h61, 1'b0, 1'b0, '0},
      '{8'h62, 1'b0, 1'b0, '0},
      '{8'h63, 1'b1, 1'b1, ABC_DIGEST},
      '{8'h00, 1'b1, 1'b0, '0},
      '{8'hff, 1'b1, 1'b0, '0},
      '{8'h55, 1'b0, 1'b0, '0},
      '{8'haa, 1'b0, 1'b0, '0},
      '{8'hff, 1'b0, 1'b0, '0},
      '{8'h00, 1'b1, 1'b0, '0},
      '{8'h61, 1'b0, 1'b0, '0},
      '{8'h62, 1'b0, 1'b0, '0},
      '{8'h63, 1'b1, 1'b1, ABC_DIGEST},
      '{8'h80, 1'b1, 1'b0, '0}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_end_of_message = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_digest_word;
   logic [1:0]  rsp_word_index;
   logic        rsp_last_word;

   sha256_byte_stream_hasher dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_digest_word    (rsp_digest_word),
      .rsp_word_index     (rsp_word_index),
      .rsp_last_word      (rsp_last_word)
   );

   always #5 clock = ~clock;

   // Predictor state: chaining words, partial block, fill and byte count.
   logic [31:0]  chain [8];
   logic [511:0] partial_block;
   int unsigned  block_fill;
   logic [63:0]  message_bytes;

   digest_slice_type pending_slices [$];
   int unsigned   fail_count = 0;
   int unsigned   cycle_count = 0;
   bit            sender_quiet = 1'b0;
   bit            receiver_quiet = 1'b0;
   int unsigned   stall_run = 0;

   function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
      return (v >> n) | (v << (32 - n));
   endfunction

   function automatic void compress_into_chain(input logic [511:0] blk);
      logic [31:0] w [64];
      logic [31:0] r [8];
      logic [31:0] t1, t2, s0, s1;
      for (int i = 0; i < 16; i++) begin
         w[i] = blk[511 - 32 * i -: 32];
      end
      for (int i = 16; i < 64; i++) begin
         s0 = rotr(w[i - 15], 7) ^ rotr(w[i - 15], 18) ^ (w[i - 15] >> 3);
         s1 = rotr(w[i - 2], 17) ^ rotr(w[i - 2], 19) ^ (w[i - 2] >> 10);
         w[i] = w[i - 16] + s0 + w[i - 7] + s1;
      end
      for (int i = 0; i < 8; i++) begin
         r[i] = chain[i];
      end
      for (int i = 0; i < 64; i++) begin
         t1 = r[7] + (rotr(r[4], 6) ^ rotr(r[4], 11) ^ rotr(r[4], 25))
            + ((r[4] & r[5]) ^ (~r[4] & r[6])) + ROUND_CONST[i] + w[i];
         t2 = (rotr(r[0], 2) ^ rotr(r[0], 13) ^ rotr(r[0], 22))
            + ((r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]));
         r[7] = r[6];
         r[6] = r[5];
         r[5] = r[4];
         r[4] = r[3] + t1;
         r[3] = r[2];
         r[2] = r[1];
         r[1] = r[0];
         r[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) begin
         chain[i] = chain[i] + r[i];
      end
   endfunction

   function automatic void restart_message();
      for (int i = 0; i < 8; i++) begin
         chain[i] = START_HASH[i];
      end
      block_fill = 0;
      message_bytes = '0;
   endfunction

   // Absorbs one byte; returns 1 with the digest when the byte ends a message.
   function automatic bit absorb_byte(input logic [7:0] b, input bit last_byte,
                                      output logic [255:0] digest);
      logic [1023:0] padded;
      padded = '0;
      digest = '0;
      partial_block[511 - 8 * block_fill -: 8] = b;
      block_fill++;
      message_bytes++;
      if (block_fill == 64) begin
         compress_into_chain(partial_block);
         block_fill = 0;
      end
      if (!last_byte) return 1'b0;
      for (int i = 0; i < block_fill; i++) begin
         padded[1023 - 8 * i -: 8] = partial_block[511 - 8 * i -: 8];
      end
      padded[1023 - 8 * block_fill -: 8] = PAD_BYTE;
      // The length goes at the end of the first block if it fits there.
      if (block_fill < 56) begin
         padded[575:512] = message_bytes << 3;
         compress_into_chain(padded[1023:512]);
      end else begin
         padded[63:0] = message_bytes << 3;
         compress_into_chain(padded[1023:512]);
         compress_into_chain(padded[511:0]);
      end
      digest = {chain[0], chain[1], chain[2], chain[3],
                chain[4], chain[5], chain[6], chain[7]};
      restart_message();
      return 1'b1;
   endfunction

   function automatic int unsigned idle_gap();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      return $urandom_range(6, 40);
   endfunction

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_byte(input logic [7:0] b, input bit last_byte,
                            input bit known, input logic [255:0] known_digest);
      int unsigned gap;
      logic [255:0] digest;
      gap = sender_quiet ? 0 : idle_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_end_of_message <= last_byte;
      do @(posedge clock); while (req_stall);
      if (absorb_byte(b, last_byte, digest)) begin
         if (known) digest = known_digest;
         for (int k = 0; k < 4; k++) begin
            pending_slices.push_back('{digest[255 - 64 * k -: 64], 2'(k),
                                       2'(k) == FINAL_SLICE});
         end
      end
      @(negedge clock);
   endtask

   task automatic send_message(input int unsigned length);
      sender_quiet = ($urandom_range(0, 3) == 0);
      for (int unsigned i = 1; i <= length; i++) begin
         send_byte(8'($urandom_range(0, 255)), i == length, 1'b0, '0);
      end
   endtask

   always @(negedge clock) begin
      if ($urandom_range(0, 199) == 0) receiver_quiet = !receiver_quiet;
      if (stall_run > 0) begin
         rsp_stall <= 1'b1;
         stall_run--;
      end else begin
         rsp_stall <= 1'b0;
         if (!receiver_quiet && $urandom_range(0, 99) < 30) stall_run = idle_gap();
      end
   end

   always @(posedge clock) begin : check_slice
      digest_slice_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_slices.size() == 0) begin
            $error("unexpected digest slice %h index %0d", rsp_digest_word, rsp_word_index);
            fail_count++;
         end else begin
            want = pending_slices.pop_front();
            if (rsp_digest_word !== want.word) begin
               $error("digest_word expected %h got %h", want.word, rsp_digest_word);
               fail_count++;
            end
            if (rsp_word_index !== want.index) begin
               $error("word_index expected %0d got %0d", want.index, rsp_word_index);
               fail_count++;
            end
            if (rsp_last_word !== want.last) begin
               $error("last_word expected %0b got %0b", want.last, rsp_last_word);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("sha256_byte_stream_hasher_test: errors");
         $finish;
      end
   end

   initial begin : stimulus
      int unsigned sent_bytes;
      int unsigned messages;
      int unsigned length;
      restart_message();
      partial_block = '0;
      sent_bytes = 0;
      messages = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         send_byte(DIRECTED[r].data, DIRECTED[r].last_byte,
                   DIRECTED[r].known, DIRECTED[r].digest);
      end

      // Lengths around the padding boundaries: the length field spilling into
      // a second block, and a block filled exactly by the last byte.
      send_message(55);
      send_message(56);
      send_message(64);
      while (sent_bytes < RANDOM_BYTES || messages < RANDOM_MESSAGES) begin
         if ($urandom_range(0, 7) == 0) length = $urandom_range(1, 130);
         else length = $urandom_range(1, 16);
         send_message(length);
         sent_bytes += length;
         messages++;
      end
      req_valid <= 1'b0;

      while (pending_slices.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("sha256_byte_stream_hasher_test: clean");
      end else begin
         $display("sha256_byte_stream_hasher_test: errors");
      end
      $finish;
   end

endmodule
